// ===== hdl/cvfp_pkg.sv =====
// Package with the shared constants, codes and types of the CORDIC vectoring unit.
package cvfp_pkg;

    localparam int ITERATIONS_DEFAULT = 15;
    localparam int COORD_BITS_DEFAULT = 16;

    localparam int TABLE_DEPTH = 15;
    localparam int INDEX_BITS  = 4;
    localparam int STEP_BITS   = 4;
    localparam int WORK_BITS   = 19;
    localparam int ANGLE_BITS  = 32;
    localparam int FIELD_BITS  = 16;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_VECTOR = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } ctrl_state_t;

    typedef struct packed {
        logic load_table;
        logic start;
        logic step;
        logic capture_next;
        logic capture_work;
    } dp_cmd_t;

    typedef struct packed {
        logic last_step;
    } dp_status_t;

endpackage

// ===== hdl/cvfp_if.sv =====
// Request and result channel interfaces of the CORDIC vectoring unit.
interface cvfp_req_if
    import cvfp_pkg::*;
;
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic [INDEX_BITS-1:0]         table_index;
    logic signed [ANGLE_BITS-1:0]  table_value;
    logic [FIELD_BITS-1:0]         x_in;
    logic [FIELD_BITS-1:0]         y_in;

    modport source (output valid, req_type, table_index, table_value, x_in, y_in,
                    input ready);
    modport sink   (input valid, req_type, table_index, table_value, x_in, y_in,
                    output ready);
endinterface

interface cvfp_rsp_if
    import cvfp_pkg::*;
;
    logic                          valid;
    logic                          ready;
    logic signed [WORK_BITS-1:0]   x_out;
    logic signed [WORK_BITS-1:0]   y_out;
    logic signed [ANGLE_BITS-1:0]  angle_out;

    modport source (output valid, x_out, y_out, angle_out, input ready);
    modport sink   (input valid, x_out, y_out, angle_out, output ready);
endinterface

// ===== hdl/cvfp_ctrl.sv =====
// Controller state machine that sequences table loads, iterations and result hand-off.
module cvfp_ctrl
    import cvfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    input  logic       req_type,
    output logic       req_ready,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        rsp_valid_reg;
    logic        rsp_valid_next;
    logic        slot_free;

    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign rsp_valid = rsp_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    if (req_type == REQ_VECTOR)
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_RUN;
                    end
                    else
                    begin
                        cmd.load_table = 1'b1;
                    end
                end
            end
            ST_RUN:
            begin
                cmd.step = 1'b1;
                if (status.last_step)
                begin
                    if (slot_free)
                    begin
                        cmd.capture_next = 1'b1;
                        state_next       = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD:
            begin
                if (slot_free)
                begin
                    cmd.capture_work = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.capture_next || cmd.capture_work)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

endmodule

// ===== hdl/cvfp_datapath.sv =====
// Datapath with the angle table, the shared shift-add iteration and the result register.
module cvfp_datapath
    import cvfp_pkg::*;
#(
    parameter int ITERATIONS = ITERATIONS_DEFAULT,
    parameter int COORD_BITS = COORD_BITS_DEFAULT
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  dp_cmd_t                      cmd,
    output dp_status_t                   status,
    input  logic [INDEX_BITS-1:0]        table_index,
    input  logic signed [ANGLE_BITS-1:0] table_value,
    input  logic [FIELD_BITS-1:0]        x_in,
    input  logic [FIELD_BITS-1:0]        y_in,
    output logic signed [WORK_BITS-1:0]  x_out,
    output logic signed [WORK_BITS-1:0]  y_out,
    output logic signed [ANGLE_BITS-1:0] angle_out
);

    logic signed [ANGLE_BITS-1:0] table_reg [TABLE_DEPTH];
    logic signed [WORK_BITS-1:0]  x_reg;
    logic signed [WORK_BITS-1:0]  y_reg;
    logic signed [ANGLE_BITS-1:0] angle_reg;
    logic [STEP_BITS-1:0]         step_reg;
    logic signed [WORK_BITS-1:0]  x_next;
    logic signed [WORK_BITS-1:0]  y_next;
    logic signed [ANGLE_BITS-1:0] angle_next;
    logic signed [ANGLE_BITS-1:0] step_angle;
    logic signed [WORK_BITS-1:0]  dx;
    logic signed [WORK_BITS-1:0]  dy;
    logic signed [WORK_BITS-1:0]  x_res_reg;
    logic signed [WORK_BITS-1:0]  y_res_reg;
    logic signed [ANGLE_BITS-1:0] angle_res_reg;

    assign status.last_step = (step_reg == STEP_BITS'(ITERATIONS - 1));

    always_comb
    begin
        dx = y_reg >>> step_reg;
        dy = x_reg >>> step_reg;
        if (step_reg < STEP_BITS'(TABLE_DEPTH))
            step_angle = table_reg[step_reg[INDEX_BITS-1:0]];
        else
            step_angle = '0;
        if (y_reg > 0)
        begin
            x_next     = x_reg + dx;
            y_next     = y_reg - dy;
            angle_next = angle_reg + step_angle;
        end
        else
        begin
            x_next     = x_reg - dx;
            y_next     = y_reg + dy;
            angle_next = angle_reg - step_angle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < TABLE_DEPTH; k++)
                table_reg[k] <= '0;
            step_reg <= '0;
        end
        else
        begin
            if (cmd.load_table && (table_index < INDEX_BITS'(TABLE_DEPTH)))
                table_reg[table_index] <= table_value;
            if (cmd.start || (cmd.step && status.last_step))
                step_reg <= '0;
            else if (cmd.step)
                step_reg <= step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            x_reg     <= $signed({{(WORK_BITS-COORD_BITS){1'b0}}, x_in[COORD_BITS-1:0]});
            y_reg     <= $signed({{(WORK_BITS-COORD_BITS){1'b0}}, y_in[COORD_BITS-1:0]});
            angle_reg <= '0;
        end
        else if (cmd.step)
        begin
            x_reg     <= x_next;
            y_reg     <= y_next;
            angle_reg <= angle_next;
        end

        if (cmd.capture_next)
        begin
            x_res_reg     <= x_next;
            y_res_reg     <= y_next;
            angle_res_reg <= angle_next;
        end
        else if (cmd.capture_work)
        begin
            x_res_reg     <= x_reg;
            y_res_reg     <= y_reg;
            angle_res_reg <= angle_reg;
        end
    end

    assign x_out     = x_res_reg;
    assign y_out     = y_res_reg;
    assign angle_out = angle_res_reg;

endmodule

// ===== hdl/cordic_vectoring_fixed_point_unit.sv =====
// Top level of the fixed-point CORDIC vectoring unit.
// A load item writes one entry of the angle table and does not stall the request channel;
// the table is cleared at reset and indexes at or above the table depth are ignored. A
// vector item is accepted and then runs ITERATIONS iterations on the single shift-add unit,
// which performs one iteration per cycle, and no request is taken meanwhile. The result waits
// in an output register, so a load item may be taken while a result is still pending; a vector
// item that completes while the previous result is untaken waits until that result is accepted.
module cordic_vectoring_fixed_point_unit
    import cvfp_pkg::*;
#(
    parameter int ITERATIONS = ITERATIONS_DEFAULT,
    parameter int COORD_BITS = COORD_BITS_DEFAULT
)
(
    input logic        clk,
    input logic        rst_n,
    cvfp_req_if.sink   req,
    cvfp_rsp_if.source rsp
);

    dp_cmd_t    cmd;
    dp_status_t status;

    cvfp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_type  (req.req_type),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    cvfp_datapath #(
        .ITERATIONS (ITERATIONS),
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .table_index (req.table_index),
        .table_value (req.table_value),
        .x_in        (req.x_in),
        .y_in        (req.y_in),
        .x_out       (rsp.x_out),
        .y_out       (rsp.y_out),
        .angle_out   (rsp.angle_out)
    );

endmodule

// ===== hdl/cvfp_checker.sv =====
// Port-level checker of the CORDIC vectoring unit and its bind to the top level.
module cvfp_port_checker
    import cvfp_pkg::*;
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_valid,
    input logic                         req_ready,
    input logic                         req_type,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic signed [WORK_BITS-1:0]  x_out,
    input logic signed [WORK_BITS-1:0]  y_out,
    input logic signed [ANGLE_BITS-1:0] angle_out
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(x_out) && $stable(y_out)
            && $stable(angle_out))
        else $error("Pending result item changed before it was taken.");

    a_vector_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_type == REQ_VECTOR) |=> !req_ready)
        else $error("Request accepted while a vector item was being worked.");

    a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_type == REQ_LOAD) |=> req_ready)
        else $error("Table load item stalled the request channel.");

    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(!req_ready))
        else $error("Result item appeared without a vector item in progress.");

endmodule

bind cordic_vectoring_fixed_point_unit cvfp_port_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_type  (req.req_type),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .x_out     (rsp.x_out),
    .y_out     (rsp.y_out),
    .angle_out (rsp.angle_out)
);
